/* hdl/rbd_pkg.sv */
// shared types and constants for the ring buffer deque unit
// no dependencies; used by rbd_cell, rbd_out_buf and ring_buffer_deque_unit
package rbd_pkg;

  localparam int unsigned DEF_CAPACITY      = 16;
  localparam int unsigned DEF_ELEMENT_WIDTH = 32;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_RIGHT,
    CMD_SHIFT_LEFT,
    CMD_APPEND,
    CMD_TAKE_LAST,
    CMD_GATHER
  } cell_cmd_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_GATHER
  } fsm_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

/* hdl/rbd_cell.sv */
// one storage cell of the deque chain: element, valid bit and gather register
// depends on rbd_pkg for the cell command encoding
module rbd_cell #(
  parameter int unsigned ELEMENT_WIDTH = rbd_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rbd_pkg::cell_cmd_e       cmd_i,
  input  logic [ELEMENT_WIDTH-1:0] push_data_i,
  input  logic [ELEMENT_WIDTH-1:0] left_data_i,
  input  logic                     left_valid_i,
  input  logic [ELEMENT_WIDTH-1:0] right_data_i,
  input  logic                     right_valid_i,
  input  logic [ELEMENT_WIDTH-1:0] right_gath_i,
  output logic [ELEMENT_WIDTH-1:0] data_o,
  output logic                     valid_o,
  output logic [ELEMENT_WIDTH-1:0] gath_o
);

  logic [ELEMENT_WIDTH-1:0] data_q, data_d;
  logic [ELEMENT_WIDTH-1:0] gath_q, gath_d;
  logic                     valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    gath_d  = gath_q;
    case (cmd_i)
      rbd_pkg::CMD_SHIFT_RIGHT: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      rbd_pkg::CMD_SHIFT_LEFT: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      rbd_pkg::CMD_APPEND: begin
        // first empty cell takes the new element
        if (!valid_q && left_valid_i) begin
          data_d  = push_data_i;
          valid_d = 1'b1;
        end
      end
      rbd_pkg::CMD_TAKE_LAST: begin
        if (valid_q && !right_valid_i) begin
          gath_d  = data_q;
          valid_d = 1'b0;
        end else begin
          gath_d  = '0;
        end
      end
      rbd_pkg::CMD_GATHER: begin
        gath_d = right_gath_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    gath_q <= gath_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign gath_o  = gath_q;

endmodule

/* hdl/rbd_out_buf.sv */
// two-entry result buffer: output register plus skid register
// depends on rbd_pkg for the result struct
module rbd_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  rbd_pkg::res_t res_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output rbd_pkg::res_t res_o,
  output logic          full_o
);

  logic          out_vld_q, out_vld_d;
  logic          skid_vld_q, skid_vld_d;
  rbd_pkg::res_t out_q, out_d;
  rbd_pkg::res_t skid_q, skid_d;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (!out_vld_q || !out_stall_i) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = res_valid_i;
        skid_d     = res_i;
      end else begin
        out_vld_d = res_valid_i;
        out_d     = res_i;
      end
    end else if (res_valid_i) begin
      skid_d     = res_i;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;
  assign full_o      = skid_vld_q;

endmodule

/* hdl/ring_buffer_deque_unit.sv */
// top level of the ring buffer deque: control sequencer, cell chain, result buffer
// depends on rbd_pkg, rbd_cell and rbd_out_buf
//
// Double-ended queue of CAPACITY elements kept in a chain of cells, front element
// in cell 0 and elements packed toward the back. Each request carries an opcode
// (push back, push front, pop back, pop front) and a value; each gives exactly one
// result with the popped value, a status (done, full, empty) and the count held
// afterwards. Push front and pop front shift the chain by one cell, push back lets
// the first free cell capture the value, and a refused request leaves the chain
// as it is. On a successful pop back the last element is picked out by its cell
// and then walks toward cell 0 through the gather registers, one cell per cycle.
// One request is in work at a time; results go through an output register with a
// skid stage, so a new request is taken while a finished result still waits
// downstream. The element storage has no reset; valid bits do.
module ring_buffer_deque_unit #(
  parameter int unsigned CAPACITY      = rbd_pkg::DEF_CAPACITY,
  parameter int unsigned ELEMENT_WIDTH = rbd_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [rbd_pkg::VALUE_W-1:0]  value_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rbd_pkg::VALUE_W-1:0]  value_out_o,
  output logic [rbd_pkg::STATUS_W-1:0] status_o,
  output logic [rbd_pkg::COUNT_W-1:0]  count_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned VW    = rbd_pkg::VALUE_W;
  localparam int unsigned CW    = rbd_pkg::COUNT_W;

  // control state
  rbd_pkg::fsm_e      state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   remain_q, remain_d;

  // chain wiring
  rbd_pkg::cell_cmd_e       cmd;
  logic [ELEMENT_WIDTH-1:0] elem;
  logic [ELEMENT_WIDTH-1:0] data_w [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] gath_w [CAPACITY];
  logic [CAPACITY-1:0]      valid_w;

  // result path
  logic          res_vld;
  rbd_pkg::res_t res;
  rbd_pkg::res_t res_out;
  logic          skid_full;

  logic          acc;
  rbd_pkg::op_e  op;
  logic          full, empty;
  logic [CNT_W-1:0] cnt_m1;

  // width fitting helpers
  logic [ELEMENT_WIDTH+VW-1:0] elem_ext;
  logic [VW+ELEMENT_WIDTH-1:0] pop_front_ext;
  logic [VW+ELEMENT_WIDTH-1:0] pop_back_ext;
  logic [CW+CNT_W-1:0]         cnt_ext;

  assign op         = rbd_pkg::op_e'(opcode_i);
  assign in_stall_o = (state_q != rbd_pkg::FSM_IDLE) || skid_full;
  assign acc        = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign cnt_m1     = count_q - 1'b1;

  assign elem_ext      = {{ELEMENT_WIDTH{1'b0}}, value_in_i};
  assign elem          = elem_ext[ELEMENT_WIDTH-1:0];
  assign pop_front_ext = {{VW{1'b0}}, data_w[0]};
  assign pop_back_ext  = {{VW{1'b0}}, gath_w[0]};
  assign cnt_ext       = {{CW{1'b0}}, count_d};

  // cell chain: cell 0 sees an always-valid left neighbor carrying the new element
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left_data, right_data, right_gath;
    logic                     left_valid, right_valid;

    if (i == 0) begin : g_first
      assign left_data  = elem;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = data_w[i-1];
      assign left_valid = valid_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
      assign right_gath  = '0;
    end else begin : g_mid_r
      assign right_data  = data_w[i+1];
      assign right_valid = valid_w[i+1];
      assign right_gath  = gath_w[i+1];
    end

    rbd_cell #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .push_data_i  (elem),
      .left_data_i  (left_data),
      .left_valid_i (left_valid),
      .right_data_i (right_data),
      .right_valid_i(right_valid),
      .right_gath_i (right_gath),
      .data_o       (data_w[i]),
      .valid_o      (valid_w[i]),
      .gath_o       (gath_w[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbd_pkg::FSM_IDLE: begin
        if (acc && (op == rbd_pkg::OP_POP_BACK) && !empty) begin
          state_d = rbd_pkg::FSM_GATHER;
        end
      end
      rbd_pkg::FSM_GATHER: begin
        if (remain_q == '0) begin
          state_d = rbd_pkg::FSM_IDLE;
        end
      end
      default: state_d = rbd_pkg::FSM_IDLE;
    endcase
  end

  // chain command, counters and result
  always_comb begin
    cmd          = rbd_pkg::CMD_HOLD;
    count_d      = count_q;
    remain_d     = remain_q;
    res_vld      = 1'b0;
    res.value    = '0;
    res.status   = rbd_pkg::ST_DONE;
    case (state_q)
      rbd_pkg::FSM_IDLE: begin
        if (acc) begin
          res_vld = 1'b1;
          case (op)
            rbd_pkg::OP_PUSH_BACK: begin
              if (full) begin
                res.status = rbd_pkg::ST_FULL;
              end else begin
                cmd     = rbd_pkg::CMD_APPEND;
                count_d = count_q + 1'b1;
              end
            end
            rbd_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                res.status = rbd_pkg::ST_FULL;
              end else begin
                cmd     = rbd_pkg::CMD_SHIFT_RIGHT;
                count_d = count_q + 1'b1;
              end
            end
            rbd_pkg::OP_POP_BACK: begin
              if (empty) begin
                res.status = rbd_pkg::ST_EMPTY;
              end else begin
                // result follows once the last element reaches cell 0
                cmd      = rbd_pkg::CMD_TAKE_LAST;
                count_d  = cnt_m1;
                remain_d = cnt_m1[IDX_W-1:0];
                res_vld  = 1'b0;
              end
            end
            rbd_pkg::OP_POP_FRONT: begin
              if (empty) begin
                res.status = rbd_pkg::ST_EMPTY;
              end else begin
                cmd       = rbd_pkg::CMD_SHIFT_LEFT;
                count_d   = cnt_m1;
                res.value = pop_front_ext[VW-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      rbd_pkg::FSM_GATHER: begin
        if (remain_q == '0) begin
          res_vld   = 1'b1;
          res.value = pop_back_ext[VW-1:0];
        end else begin
          cmd      = rbd_pkg::CMD_GATHER;
          remain_d = remain_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.count = cnt_ext[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rbd_pkg::FSM_IDLE;
      count_q  <= '0;
      remain_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      remain_q <= remain_d;
    end
  end

  rbd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_vld),
    .res_i      (res),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .res_o      (res_out),
    .full_o     (skid_full)
  );

  assign value_out_o = res_out.value;
  assign status_o    = res_out.status;
  assign count_o     = res_out.count;

  // occupancy never exceeds the ring
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  // valid bits in the chain agree with the count
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == 32'(count_q))
    else $error("cell valid bits disagree with held count");

  // a request other than a successful pop back always leaves a result at the output
  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !((op == rbd_pkg::OP_POP_BACK) && !empty) |=> out_valid_o)
    else $error("result missing after single-cycle request");

  // the gather walk never starts longer than the chain
  a_gather_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbd_pkg::FSM_GATHER) |-> (32'(remain_q) < 32'(count_q) + 1))
    else $error("gather distance beyond held elements");

endmodule
